>>> hw/rtl/lpfa_pkg.sv
// Shared types and constants for the Lennard-Jones pair force accumulator.
// No dependencies; every other file of the block but lpfa_checker imports this package.
package lpfa_pkg;

   localparam int FIELD_W   = 32;
   localparam int MAG_W     = 64;
   localparam int HALF_W    = 32;
   localparam int PROD_W    = 128;
   localparam int CSR_IDX_W = 3;
   localparam int Q_DEPTH   = 4;
   localparam int Q_PTR_W   = $clog2(Q_DEPTH);

   localparam logic [FIELD_W-1:0] SIGMA_POW6_RST = 32'd65536;
   localparam logic [FIELD_W-1:0] WELL_DEPTH_RST = 32'd65536;
   localparam logic [FIELD_W-1:0] CUTOFF_SQ_RST  = 32'd409600;
   localparam logic [FIELD_W-1:0] BOX_LEN_RST    = 32'd0;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SIGMA_POW6 = 3'd0,
      CSR_WELL_DEPTH = 3'd1,
      CSR_CUTOFF_SQ  = 3'd2,
      CSR_BOX_X      = 3'd3,
      CSR_BOX_Y      = 3'd4,
      CSR_BOX_Z      = 3'd5
   } csr_index_type;

   // one classified pair as it waits between front and back
   typedef struct packed {
      logic signed [FIELD_W-1:0] dx;
      logic signed [FIELD_W-1:0] dy;
      logic signed [FIELD_W-1:0] dz;
      logic                      skip;
      logic                      last;
   } pair_type;

   typedef struct packed {
      logic             start;
      logic             neg;
      logic [MAG_W-1:0] a_mag;
      logic [MAG_W-1:0] b_mag;
   } mul_req_type;

   typedef enum logic [3:0] {
      ST_FETCH = 4'b0001,
      ST_ISSUE = 4'b0010,
      ST_WAIT  = 4'b0100,
      ST_HOLD  = 4'b1000
   } back_state_type;

   typedef enum logic [4:0] {
      U_SQX  = 5'd0,
      U_SQY  = 5'd1,
      U_SQZ  = 5'd2,
      U_DIV  = 5'd3,
      U_INV2 = 5'd4,
      U_R6   = 5'd5,
      U_T    = 5'd6,
      U_E    = 5'd7,
      U_K    = 5'd8,
      U_F1   = 5'd9,
      U_F2   = 5'd10,
      U_F3   = 5'd11,
      U_F4   = 5'd12,
      U_F5   = 5'd13,
      U_FX   = 5'd14,
      U_FY   = 5'd15,
      U_FZ   = 5'd16,
      U_S1   = 5'd17,
      U_S2   = 5'd18,
      U_ES   = 5'd19
   } step_type;

endpackage

>>> hw/rtl/lpfa_front.sv
// Front end: wraps cell offsets, forms the displacement, flags far pairs,
// and queues classified pairs for the back end. Depends on lpfa_pkg.
module lpfa_front
   import lpfa_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   output logic                      full,
   input  logic signed [FIELD_W-1:0] atom_dx,
   input  logic signed [FIELD_W-1:0] atom_dy,
   input  logic signed [FIELD_W-1:0] atom_dz,
   input  logic signed [FIELD_W-1:0] cell_dx,
   input  logic signed [FIELD_W-1:0] cell_dy,
   input  logic signed [FIELD_W-1:0] cell_dz,
   input  logic                      last_pair,
   input  logic [FIELD_W-1:0]        box_x,
   input  logic [FIELD_W-1:0]        box_y,
   input  logic [FIELD_W-1:0]        box_z,
   input  logic                      pop,
   output logic                      empty,
   output pair_type                  head
);

   localparam int DW = FIELD_W + 3;
   localparam logic signed [DW-1:0] D_LIM = 35'sd2147483647;

   function automatic logic signed [DW-1:0] displace(
      input logic signed [FIELD_W-1:0] atom,
      input logic signed [FIELD_W-1:0] cell_ofs,
      input logic [FIELD_W-1:0]        box
   );
      logic signed [DW-1:0] c;
      logic signed [DW-1:0] c2;
      logic signed [DW-1:0] b;
      logic signed [DW-1:0] w;
      c  = DW'(cell_ofs);
      c2 = c <<< 1;
      b  = signed'(DW'(box));
      if (c2 < -b) begin
         w = c + b;
      end else if (c2 > b) begin
         w = c - b;
      end else begin
         w = c;
      end
      return DW'(atom) + w;
   endfunction

   logic signed [DW-1:0] d_x, d_y, d_z;
   logic                 in_range;
   pair_type             entry;
   logic                 wr_en;

   pair_type             mem_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [Q_PTR_W:0]     cnt_ff;

   always_comb begin
      d_x = displace(atom_dx, cell_dx, box_x);
      d_y = displace(atom_dy, cell_dy, box_y);
      d_z = displace(atom_dz, cell_dz, box_z);
      in_range = (d_x >= -D_LIM) && (d_x <= D_LIM) &&
                 (d_y >= -D_LIM) && (d_y <= D_LIM) &&
                 (d_z >= -D_LIM) && (d_z <= D_LIM);
      entry.dx   = signed'(d_x[FIELD_W-1:0]);
      entry.dy   = signed'(d_y[FIELD_W-1:0]);
      entry.dz   = signed'(d_z[FIELD_W-1:0]);
      entry.skip = !in_range;
      entry.last = last_pair;
   end

   assign full  = (cnt_ff == (Q_PTR_W+1)'(Q_DEPTH));
   assign empty = (cnt_ff == '0);
   assign wr_en = push && !full;
   assign head  = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_ptr_ff] <= entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (wr_en) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (wr_en && !pop) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (pop && !wr_en) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

endmodule

>>> hw/rtl/lpfa_qmul.sv
// Fixed-point multiplier: 64x64 magnitudes in four 32x32 partial products,
// then round to nearest (ties away) and saturate. Depends on lpfa_pkg.
module lpfa_qmul
   import lpfa_pkg::*;
#(
   parameter int FRAC_BITS = 16,
   parameter int ACC_WIDTH = 48
)(
   input  logic                        clock,
   input  logic                        reset,
   input  mul_req_type                 req,
   output logic                        done,
   output logic signed [ACC_WIDTH-1:0] res,
   output logic [MAG_W-1:0]            prod_lo
);

   localparam logic [PROD_W-1:0] RND     = PROD_W'(1) << (FRAC_BITS - 1);
   localparam logic [PROD_W-1:0] LIM_NEG = PROD_W'(1) << (ACC_WIDTH - 1);
   localparam logic [PROD_W-1:0] LIM_POS = LIM_NEG - PROD_W'(1);

   logic                        busy_ff;
   logic [2:0]                  cnt_ff;
   logic [MAG_W-1:0]            a_ff, b_ff, pp_ff;
   logic                        neg_ff;
   logic [1:0]                  pos_ff;
   logic [PROD_W-1:0]           acc_ff;
   logic                        done_ff;
   logic signed [ACC_WIDTH-1:0] res_ff;

   logic [HALF_W-1:0]           a_half, b_half;
   logic [MAG_W-1:0]            pp_in;
   logic [PROD_W-1:0]           shifted, rounded, mag, lim, mag_sat;
   logic [ACC_WIDTH-1:0]        mag_aw;
   logic signed [ACC_WIDTH-1:0] res_in;

   always_comb begin
      a_half  = cnt_ff[1] ? a_ff[MAG_W-1:HALF_W] : a_ff[HALF_W-1:0];
      b_half  = cnt_ff[0] ? b_ff[MAG_W-1:HALF_W] : b_ff[HALF_W-1:0];
      pp_in   = MAG_W'(a_half) * MAG_W'(b_half);
      shifted = PROD_W'(pp_ff) << {pos_ff, 5'b00000};
      rounded = acc_ff + RND;
      mag     = rounded >> FRAC_BITS;
      lim     = neg_ff ? LIM_NEG : LIM_POS;
      mag_sat = (mag > lim) ? lim : mag;
      mag_aw  = mag_sat[ACC_WIDTH-1:0];
      res_in  = neg_ff ? signed'(-mag_aw) : signed'(mag_aw);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            a_ff    <= req.a_mag;
            b_ff    <= req.b_mag;
            neg_ff  <= req.neg;
            acc_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff <= 3'd3) begin
               pp_ff  <= pp_in;
               pos_ff <= {1'b0, cnt_ff[1]} + {1'b0, cnt_ff[0]};
            end
            if (cnt_ff >= 3'd1 && cnt_ff <= 3'd4) begin
               acc_ff <= acc_ff + shifted;
            end
            if (cnt_ff == 3'd5) begin
               res_ff  <= res_in;
               done_ff <= 1'b1;
               busy_ff <= 1'b0;
            end
         end
      end
   end

   assign done    = done_ff;
   assign res     = res_ff;
   assign prod_lo = acc_ff[MAG_W-1:0];

endmodule

>>> hw/rtl/lpfa_div.sv
// Restoring divider, one quotient bit per cycle, for the inverse of r squared.
// Depends on lpfa_pkg.
module lpfa_div
   import lpfa_pkg::*;
#(
   parameter int NUM_W = 33
)(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [NUM_W-1:0]   num,
   input  logic [FIELD_W-1:0] den,
   output logic               done,
   output logic [NUM_W-1:0]   quo
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic               busy_ff, done_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [NUM_W-1:0]   num_ff, quo_ff;
   logic [FIELD_W-1:0] den_ff, rem_ff;
   logic [FIELD_W:0]   trial;
   logic               fits;

   always_comb begin
      trial = {rem_ff, num_ff[NUM_W-1]};
      fits  = (trial >= {1'b0, den_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(NUM_W);
            num_ff  <= num;
            den_ff  <= den;
            rem_ff  <= '0;
            quo_ff  <= '0;
         end else if (busy_ff) begin
            num_ff <= num_ff << 1;
            quo_ff <= {quo_ff[NUM_W-2:0], fits};
            rem_ff <= fits ? FIELD_W'(trial - {1'b0, den_ff}) : trial[FIELD_W-1:0];
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

>>> hw/rtl/lpfa_back.sv
// Back end: sequences one pair at a time through a shared multiplier and a
// divider, keeps the saturating sums and the result register. Uses lpfa_pkg.
module lpfa_back
   import lpfa_pkg::*;
#(
   parameter int FRAC_BITS = 16,
   parameter int ACC_WIDTH = 48
)(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        q_empty,
   input  pair_type                    q_head,
   output logic                        q_pop,
   input  logic [FIELD_W-1:0]          sigma_pow6,
   input  logic [FIELD_W-1:0]          well_depth,
   input  logic [FIELD_W-1:0]          cutoff_sq,
   output logic                        rsp_empty,
   input  logic                        rsp_pop,
   output logic signed [ACC_WIDTH-1:0] force_x,
   output logic signed [ACC_WIDTH-1:0] force_y,
   output logic signed [ACC_WIDTH-1:0] force_z,
   output logic signed [ACC_WIDTH-1:0] energy_share
);

   localparam int AW    = ACC_WIDTH;
   localparam int NUM_W = (2 * FRAC_BITS + 1 > 33) ? 2 * FRAC_BITS + 1 : 33;

   localparam logic signed [AW-1:0] SAT_MAX   = {1'b0, {(AW-1){1'b1}}};
   localparam logic signed [AW-1:0] SAT_MIN   = {1'b1, {(AW-1){1'b0}}};
   localparam logic signed [AW-1:0] ONE_Q     = AW'(1) << FRAC_BITS;
   localparam logic signed [AW-1:0] TWO_Q     = AW'(2) << FRAC_BITS;
   localparam logic signed [AW-1:0] FOUR_Q    = AW'(4) << FRAC_BITS;
   localparam logic signed [AW-1:0] TWELVE_Q  = AW'(12) << FRAC_BITS;
   localparam logic signed [AW-1:0] NEG_ONE_Q = -ONE_Q;
   localparam logic signed [AW-1:0] NEG_SIX_Q = -(AW'(6) << FRAC_BITS);
   localparam logic [NUM_W-1:0]     NUM_BASE  = NUM_W'(1) << (2 * FRAC_BITS);

   function automatic logic signed [AW-1:0] sat_add(
      input logic signed [AW-1:0] a,
      input logic signed [AW-1:0] b
   );
      logic [AW:0] s;
      s = {a[AW-1], a} + {b[AW-1], b};
      if (s[AW] != s[AW-1]) begin
         return s[AW] ? SAT_MIN : SAT_MAX;
      end
      return signed'(s[AW-1:0]);
   endfunction

   function automatic logic [MAG_W-1:0] mag_of(input logic signed [AW-1:0] v);
      logic [AW-1:0] u;
      u = v[AW-1] ? (~v + 1'b1) : v;
      return MAG_W'(u);
   endfunction

   function automatic logic [MAG_W-1:0] dmag_of(input logic signed [FIELD_W-1:0] v);
      logic [FIELD_W-1:0] u;
      u = v[FIELD_W-1] ? (~v + 1'b1) : v;
      return MAG_W'(u);
   endfunction

   back_state_type      state_ff, state_in;
   step_type            step_ff, step_in;
   pair_type            cur_ff;
   logic [MAG_W-1:0]    sq_ff;
   logic [FIELD_W-1:0]  r2_ff;
   logic signed [AW-1:0] inv_ff, r6_ff, t_ff, e_ff, k_ff, f_ff;
   logic signed [AW-1:0] sum_x_ff, sum_y_ff, sum_z_ff, sum_e_ff;
   logic                 out_valid_ff;
   logic signed [AW-1:0] out_x_ff, out_y_ff, out_z_ff, out_e_ff;

   mul_req_type          mreq;
   logic                 mul_done, div_done, unit_done;
   logic signed [AW-1:0] mres;
   logic [MAG_W-1:0]     prod_lo, sq_sum, r2_full;
   logic                 pair_hit;
   logic [NUM_W-1:0]     div_num, div_quo;
   logic signed [AW-1:0] inv_sat, t_minus_one;
   logic                 opa_neg, opb_neg;
   logic [MAG_W-1:0]     opa_mag, opb_mag;
   back_state_type       end_state;

   always_comb begin
      sq_sum      = sq_ff + prod_lo;
      r2_full     = sq_sum >> FRAC_BITS;
      pair_hit    = (r2_full != '0) && (r2_full <= MAG_W'(cutoff_sq));
      div_num     = NUM_BASE + NUM_W'(r2_ff >> 1);
      inv_sat     = (div_quo > NUM_W'(SAT_MAX)) ? SAT_MAX : AW'(div_quo);
      t_minus_one = sat_add(t_ff, NEG_ONE_Q);
      end_state   = cur_ff.last ? ST_HOLD : ST_FETCH;
      unit_done   = (step_ff == U_DIV) ? div_done : mul_done;
   end

   // operand select per step
   always_comb begin
      opa_mag = '0;
      opb_mag = '0;
      opa_neg = 1'b0;
      opb_neg = 1'b0;
      case (step_ff)
         U_SQX: begin
            opa_mag = dmag_of(cur_ff.dx);
            opb_mag = dmag_of(cur_ff.dx);
         end
         U_SQY: begin
            opa_mag = dmag_of(cur_ff.dy);
            opb_mag = dmag_of(cur_ff.dy);
         end
         U_SQZ: begin
            opa_mag = dmag_of(cur_ff.dz);
            opb_mag = dmag_of(cur_ff.dz);
         end
         U_INV2: begin
            opa_mag = mag_of(inv_ff);  opa_neg = inv_ff[AW-1];
            opb_mag = mag_of(inv_ff);  opb_neg = inv_ff[AW-1];
         end
         U_R6: begin
            opa_mag = mag_of(f_ff);    opa_neg = f_ff[AW-1];
            opb_mag = mag_of(inv_ff);  opb_neg = inv_ff[AW-1];
         end
         U_T: begin
            opa_mag = MAG_W'(sigma_pow6);
            opb_mag = mag_of(r6_ff);   opb_neg = r6_ff[AW-1];
         end
         U_E: begin
            opa_mag = mag_of(r6_ff);   opa_neg = r6_ff[AW-1];
            opb_mag = mag_of(t_minus_one);
            opb_neg = t_minus_one[AW-1];
         end
         U_K: begin
            opa_mag = mag_of(t_ff);    opa_neg = t_ff[AW-1];
            opb_mag = mag_of(TWELVE_Q);
         end
         U_F1, U_S1: begin
            opa_mag = MAG_W'(well_depth);
            opb_mag = MAG_W'(sigma_pow6);
         end
         U_F2: begin
            opa_mag = mag_of(f_ff);    opa_neg = f_ff[AW-1];
            opb_mag = mag_of(inv_ff);  opb_neg = inv_ff[AW-1];
         end
         U_F3: begin
            opa_mag = mag_of(f_ff);    opa_neg = f_ff[AW-1];
            opb_mag = mag_of(r6_ff);   opb_neg = r6_ff[AW-1];
         end
         U_F4: begin
            opa_mag = mag_of(f_ff);    opa_neg = f_ff[AW-1];
            opb_mag = mag_of(k_ff);    opb_neg = k_ff[AW-1];
         end
         U_F5: begin
            opa_mag = mag_of(f_ff);    opa_neg = f_ff[AW-1];
            opb_mag = mag_of(FOUR_Q);
         end
         U_FX: begin
            opa_mag = dmag_of(cur_ff.dx); opa_neg = cur_ff.dx[FIELD_W-1];
            opb_mag = mag_of(f_ff);       opb_neg = f_ff[AW-1];
         end
         U_FY: begin
            opa_mag = dmag_of(cur_ff.dy); opa_neg = cur_ff.dy[FIELD_W-1];
            opb_mag = mag_of(f_ff);       opb_neg = f_ff[AW-1];
         end
         U_FZ: begin
            opa_mag = dmag_of(cur_ff.dz); opa_neg = cur_ff.dz[FIELD_W-1];
            opb_mag = mag_of(f_ff);       opb_neg = f_ff[AW-1];
         end
         U_S2: begin
            opa_mag = mag_of(f_ff);    opa_neg = f_ff[AW-1];
            opb_mag = mag_of(TWO_Q);
         end
         U_ES: begin
            opa_mag = mag_of(sum_e_ff); opa_neg = sum_e_ff[AW-1];
            opb_mag = mag_of(f_ff);     opb_neg = f_ff[AW-1];
         end
         default: begin
         end
      endcase
      mreq.start = (state_ff == ST_ISSUE) && (step_ff != U_DIV);
      mreq.neg   = opa_neg ^ opb_neg;
      mreq.a_mag = opa_mag;
      mreq.b_mag = opb_mag;
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      q_pop    = 1'b0;
      case (state_ff)
         ST_FETCH: begin
            if (!q_empty) begin
               q_pop = 1'b1;
               if (q_head.skip) begin
                  state_in = q_head.last ? ST_HOLD : ST_FETCH;
               end else begin
                  step_in  = U_SQX;
                  state_in = ST_ISSUE;
               end
            end
         end
         ST_ISSUE: begin
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (unit_done) begin
               case (step_ff)
                  U_SQZ: begin
                     if (pair_hit) begin
                        step_in  = U_DIV;
                        state_in = ST_ISSUE;
                     end else begin
                        state_in = end_state;
                     end
                  end
                  U_FZ: state_in = end_state;
                  U_ES: state_in = ST_FETCH;
                  default: begin
                     step_in  = step_type'(step_ff + 1'b1);
                     state_in = ST_ISSUE;
                  end
               endcase
            end
         end
         ST_HOLD: begin
            // wait for the result register to drain before closing the atom
            if (!out_valid_ff) begin
               step_in  = U_S1;
               state_in = ST_ISSUE;
            end
         end
         default: state_in = ST_FETCH;
      endcase
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         cur_ff <= q_head;
      end
      if (state_ff == ST_WAIT && unit_done) begin
         case (step_ff)
            U_SQX:                        sq_ff  <= prod_lo;
            U_SQY:                        sq_ff  <= sq_sum;
            U_SQZ:                        r2_ff  <= r2_full[FIELD_W-1:0];
            U_DIV:                        inv_ff <= inv_sat;
            U_R6:                         r6_ff  <= mres;
            U_T:                          t_ff   <= mres;
            U_E:                          e_ff   <= mres;
            U_K:                          k_ff   <= sat_add(mres, NEG_SIX_Q);
            U_INV2, U_F1, U_F2, U_F3,
            U_F4, U_F5, U_S1, U_S2:       f_ff   <= mres;
            U_ES: begin
               out_x_ff <= sum_x_ff;
               out_y_ff <= sum_y_ff;
               out_z_ff <= sum_z_ff;
               out_e_ff <= mres;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_FETCH;
         step_ff      <= U_SQX;
         out_valid_ff <= 1'b0;
         sum_x_ff     <= '0;
         sum_y_ff     <= '0;
         sum_z_ff     <= '0;
         sum_e_ff     <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         if (rsp_pop && out_valid_ff) begin
            out_valid_ff <= 1'b0;
         end
         if (state_ff == ST_WAIT && unit_done) begin
            case (step_ff)
               U_FX: sum_x_ff <= sat_add(sum_x_ff, mres);
               U_FY: sum_y_ff <= sat_add(sum_y_ff, mres);
               U_FZ: begin
                  sum_z_ff <= sat_add(sum_z_ff, mres);
                  sum_e_ff <= sat_add(sum_e_ff, e_ff);
               end
               U_ES: begin
                  out_valid_ff <= 1'b1;
                  sum_x_ff     <= '0;
                  sum_y_ff     <= '0;
                  sum_z_ff     <= '0;
                  sum_e_ff     <= '0;
               end
               default: begin
               end
            endcase
         end
      end
   end

   lpfa_qmul #(
      .FRAC_BITS (FRAC_BITS),
      .ACC_WIDTH (ACC_WIDTH)
   ) u_qmul (
      .clock   (clock),
      .reset   (reset),
      .req     (mreq),
      .done    (mul_done),
      .res     (mres),
      .prod_lo (prod_lo)
   );

   lpfa_div #(
      .NUM_W (NUM_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start ((state_ff == ST_ISSUE) && (step_ff == U_DIV)),
      .num   (div_num),
      .den   (r2_ff),
      .done  (div_done),
      .quo   (div_quo)
   );

   assign rsp_empty    = !out_valid_ff;
   assign force_x      = out_x_ff;
   assign force_y      = out_y_ff;
   assign force_z      = out_z_ff;
   assign energy_share = out_e_ff;

endmodule

>>> hw/rtl/lj_pair_force_accumulator_top.sv
// Top level of the Lennard-Jones 12-6 pair force accumulator: register file,
// front end and back end. Depends on lpfa_pkg, lpfa_front and lpfa_back.
//
//   channel   direction  handshake              payload
//   req_      in         req_push / req_full    atom_d*, cell_d*, last_pair
//   rsp_      out        rsp_pop / rsp_empty    force_x/y/z, energy_share
//   csr_      in         csr_valid / csr_ready  csr_index, csr_wdata
//
// The front end takes one beat per cycle, while req_full is low, into a
// 4-entry pair queue. The back end drains it one pair at a time on a shared
// multiplier built from 32x32 partial products and a bit-serial divider
// (2*FRAC_BITS+1 bits, at least 33): an in-range pair takes 16 products and
// one division, a far pair none, a pair beyond cutoff only the three squares,
// and the last pair of an atom 3 more products for the energy share.
// Reset is synchronous, clears the sums and empties queue and result
// register; no clearing pass. req_full rises only when the queue holds four
// pairs, and a waiting result stalls the back end only when the next atom closes.
module lj_pair_force_accumulator_top
   import lpfa_pkg::*;
#(
   parameter int FRAC_BITS = 16,
   parameter int ACC_WIDTH = 48
)(
   input  logic                        clock,
   input  logic                        reset,
   // pair input
   input  logic                        req_push,
   output logic                        req_full,
   input  logic signed [FIELD_W-1:0]   req_atom_dx,
   input  logic signed [FIELD_W-1:0]   req_atom_dy,
   input  logic signed [FIELD_W-1:0]   req_atom_dz,
   input  logic signed [FIELD_W-1:0]   req_cell_dx,
   input  logic signed [FIELD_W-1:0]   req_cell_dy,
   input  logic signed [FIELD_W-1:0]   req_cell_dz,
   input  logic                        req_last_pair,
   // result output
   output logic                        rsp_empty,
   input  logic                        rsp_pop,
   output logic signed [ACC_WIDTH-1:0] rsp_force_x,
   output logic signed [ACC_WIDTH-1:0] rsp_force_y,
   output logic signed [ACC_WIDTH-1:0] rsp_force_z,
   output logic signed [ACC_WIDTH-1:0] rsp_energy_share,
   // register writes
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [FIELD_W-1:0]          csr_wdata
);

   logic [FIELD_W-1:0] sigma_pow6_ff, well_depth_ff, cutoff_sq_ff;
   logic [FIELD_W-1:0] box_x_ff, box_y_ff, box_z_ff;

   logic     q_empty, q_pop;
   pair_type q_head;

   // writes are always taken; unknown indexes drop silently
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         sigma_pow6_ff <= SIGMA_POW6_RST;
         well_depth_ff <= WELL_DEPTH_RST;
         cutoff_sq_ff  <= CUTOFF_SQ_RST;
         box_x_ff      <= BOX_LEN_RST;
         box_y_ff      <= BOX_LEN_RST;
         box_z_ff      <= BOX_LEN_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_SIGMA_POW6: sigma_pow6_ff <= csr_wdata;
            CSR_WELL_DEPTH: well_depth_ff <= csr_wdata;
            CSR_CUTOFF_SQ:  cutoff_sq_ff  <= csr_wdata;
            CSR_BOX_X:      box_x_ff      <= csr_wdata;
            CSR_BOX_Y:      box_y_ff      <= csr_wdata;
            CSR_BOX_Z:      box_z_ff      <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // wrap, classify and queue
   lpfa_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .full      (req_full),
      .atom_dx   (req_atom_dx),
      .atom_dy   (req_atom_dy),
      .atom_dz   (req_atom_dz),
      .cell_dx   (req_cell_dx),
      .cell_dy   (req_cell_dy),
      .cell_dz   (req_cell_dz),
      .last_pair (req_last_pair),
      .box_x     (box_x_ff),
      .box_y     (box_y_ff),
      .box_z     (box_z_ff),
      .pop       (q_pop),
      .empty     (q_empty),
      .head      (q_head)
   );

   // force and energy arithmetic, accumulation, result register
   lpfa_back #(
      .FRAC_BITS (FRAC_BITS),
      .ACC_WIDTH (ACC_WIDTH)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .q_empty      (q_empty),
      .q_head       (q_head),
      .q_pop        (q_pop),
      .sigma_pow6   (sigma_pow6_ff),
      .well_depth   (well_depth_ff),
      .cutoff_sq    (cutoff_sq_ff),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .force_x      (rsp_force_x),
      .force_y      (rsp_force_y),
      .force_z      (rsp_force_z),
      .energy_share (rsp_energy_share)
   );

endmodule

>>> hw/rtl/lpfa_checker.sv
// Port-level checks for the pair force accumulator, bound to the top level.
// Depends on lj_pair_force_accumulator_top.
module lpfa_checker #(
   parameter int ACC_WIDTH = 48
)(
   input logic                        clock,
   input logic                        reset,
   input logic                        req_push,
   input logic                        req_full,
   input logic                        rsp_empty,
   input logic                        rsp_pop,
   input logic signed [ACC_WIDTH-1:0] rsp_force_x,
   input logic signed [ACC_WIDTH-1:0] rsp_force_y,
   input logic signed [ACC_WIDTH-1:0] rsp_force_z,
   input logic signed [ACC_WIDTH-1:0] rsp_energy_share
);

   a_reset_clears: assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("queue or result not cleared by reset");

   a_full_needs_push: assert property (@(posedge clock) disable iff (reset)
      $rose(req_full) |-> $past(req_push && !req_full))
      else $error("pair queue filled without an accepted beat");

   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty)
      else $error("result withdrawn before pop");

   a_result_stable: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> $stable(rsp_force_x) && $stable(rsp_force_y) &&
                                 $stable(rsp_force_z) && $stable(rsp_energy_share))
      else $error("result payload changed while stalled");

endmodule

bind lj_pair_force_accumulator_top lpfa_checker #(.ACC_WIDTH(ACC_WIDTH)) u_lpfa_checker (.*);
